@@ sv/rnf_pkg.sv @@
// Shared types and constants for the RSSI noise floor estimator.
package rnf_pkg;

	localparam int RNF_SAMPLE_COUNT = 64;
	localparam int ACCEPT_MARGIN    = 14;
	localparam int FLOOR_MIN        = -120;
	localparam int FLOOR_MAX        = 127;
	localparam int TOTAL_W          = 16;

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_TRIGGER = 1'b1;

	typedef struct packed {
		logic              kind;
		logic signed [8:0] rssi_sample;
		logic              in_receive_mode;
		logic signed [7:0] new_threshold;
	} item_t;

	typedef struct packed {
		logic signed [7:0] floor_level;
		logic              channel_busy;
		logic              sampling_active;
		logic              floor_updated;
	} res_t;

endpackage

@@ sv/rnf_avg.sv @@
// Average of the sample total over the sample count, truncated toward zero and clamped.
module rnf_avg import rnf_pkg::*; #(
	parameter int SAMPLE_COUNT = RNF_SAMPLE_COUNT
) (
	input  logic signed [TOTAL_W-1:0] total,
	output logic signed [7:0]         avg
);

	// Exact reciprocal for every 16-bit magnitude: m = ceil(2^(16+l) / N)
	localparam int    L_W    = $clog2(SAMPLE_COUNT);
	localparam int    SHIFT  = TOTAL_W + L_W;
	localparam int    RECIP_W = TOTAL_W + 2;
	localparam int    PROD_W = TOTAL_W + RECIP_W;
	localparam longint RECIP = ((64'sd1 <<< SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
	localparam logic [PROD_W-1:0] FLOOR_MIN_MAG = PROD_W'(-FLOOR_MIN);
	localparam logic [PROD_W-1:0] FLOOR_MAX_MAG = PROD_W'(FLOOR_MAX);

	logic [TOTAL_W-1:0] mag;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  quo;

	always_comb begin
		// magnitude of the most negative total still fits as unsigned
		mag  = total[TOTAL_W-1] ? (~total + TOTAL_W'(1)) : total;
		prod = PROD_W'(mag) * PROD_W'(RECIP);
		quo  = prod >> SHIFT;
		if (total[TOTAL_W-1]) begin
			if (quo >= FLOOR_MIN_MAG) begin
				avg = 8'(FLOOR_MIN);
			end else begin
				avg = 8'(~quo[7:0] + 8'd1);
			end
		end else begin
			if (quo > FLOOR_MAX_MAG) begin
				avg = 8'(FLOOR_MAX);
			end else begin
				avg = quo[7:0];
			end
		end
	end

endmodule

@@ sv/rnf_update.sv @@
// Estimator state registers and the per-item update and result logic.
module rnf_update import rnf_pkg::*; #(
	parameter int SAMPLE_COUNT = RNF_SAMPLE_COUNT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output res_t  result
);

	localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(SAMPLE_COUNT);
	localparam logic signed [9:0] MARGIN10 = 10'(ACCEPT_MARGIN);
	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX_V = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN_V = {1'b1, {(TOTAL_W-1){1'b0}}};

	logic signed [7:0]         floor_q, floor_n;
	logic [CNT_W-1:0]          cnt_q, cnt_n;
	logic signed [TOTAL_W-1:0] total_q, total_n;
	logic signed [7:0]         margin_q, margin_n;

	logic signed [7:0]         avg;
	logic                      full;
	logic signed [9:0]         accept_lim;
	logic signed [9:0]         rssi10;
	logic signed [TOTAL_W:0]   sum;
	logic signed [10:0]        busy_lim;
	logic signed [10:0]        rssi11;
	logic                      updated;

	rnf_avg #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_avg (
		.total (total_q),
		.avg   (avg)
	);

	always_comb begin
		full       = cnt_q >= FULL;
		rssi10     = {item.rssi_sample[8], item.rssi_sample};
		accept_lim = {{2{floor_q[7]}}, floor_q} + MARGIN10;
		sum        = {total_q[TOTAL_W-1], total_q}
			+ {{(TOTAL_W-8){item.rssi_sample[8]}}, item.rssi_sample};
		floor_n    = floor_q;
		cnt_n      = cnt_q;
		total_n    = total_q;
		margin_n   = margin_q;
		updated    = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (item.in_receive_mode && !full) begin
					if (rssi10 < accept_lim) begin
						cnt_n = cnt_q + CNT_W'(1);
						// saturate the running total
						if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
							total_n = sum[TOTAL_W] ? TOTAL_MIN_V : TOTAL_MAX_V;
						end else begin
							total_n = sum[TOTAL_W-1:0];
						end
					end
				end else if (full && total_q != '0) begin
					floor_n = avg;
					total_n = '0;
					updated = 1'b1;
				end
			end
			KIND_TRIGGER: begin
				margin_n = item.new_threshold;
				if (full) begin
					cnt_n   = '0;
					total_n = '0;
				end
			end
			default: begin
				updated = 1'b0;
			end
		endcase
		rssi11   = {{2{item.rssi_sample[8]}}, item.rssi_sample};
		busy_lim = {{3{floor_n[7]}}, floor_n} + {{3{margin_n[7]}}, margin_n};
		result.floor_level     = floor_n;
		result.channel_busy    = (margin_n != '0) && (rssi11 > busy_lim);
		result.sampling_active = cnt_n < FULL;
		result.floor_updated   = updated;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q  <= '0;
			cnt_q    <= '0;
			total_q  <= '0;
			margin_q <= '0;
		end else if (step) begin
			floor_q  <= floor_n;
			cnt_q    <= cnt_n;
			total_q  <= total_n;
			margin_q <= margin_n;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("gathered count beyond sample count");

	a_floor_min: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q >= 8'(FLOOR_MIN))
		else $error("floor below clamp");

	a_total_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && updated |=> total_q == '0 && floor_q == $past(avg))
		else $error("floor update did not load average and clear total");
`endif

endmodule

@@ sv/rssi_noise_floor_estimator.sv @@
// An accepted item waits in the input register; its result loads the result register
// when that register is empty or out_ready is high, and out_valid then rises.
// Throughput: one item per cycle while out_ready is high; the estimator state updates
// as the result registers. While a finished result waits for out_ready the input
// register takes one more item, then in_ready drops. Reset (arst_n low, asynchronous):
// both stages empty, state zero. Top level of the RSSI noise floor estimator.
module rssi_noise_floor_estimator import rnf_pkg::*; #(
	parameter int SAMPLE_COUNT = RNF_SAMPLE_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic signed [8:0] rssi_sample,
	input  logic              in_receive_mode,
	input  logic signed [7:0] new_threshold,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] floor_level,
	output logic              channel_busy,
	output logic              sampling_active,
	output logic              floor_updated
);

	// input register
	item_t item_s1;
	logic  valid_s1;

	// result register
	res_t  res_s2;
	logic  valid_s2;

	res_t  res;
	logic  advance;

	// move the held item into the result register when that register frees up
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: capture on acceptance only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: kind, rssi_sample: rssi_sample,
				in_receive_mode: in_receive_mode, new_threshold: new_threshold};
		end
	end

	// state advances exactly once per item, as its result loads
	rnf_update #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign floor_level     = res_s2.floor_level;
	assign channel_busy    = res_s2.channel_busy;
	assign sampling_active = res_s2.sampling_active;
	assign floor_updated   = res_s2.floor_updated;

`ifndef SYNTHESIS
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item did not produce a result");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled item lost from input register");
`endif

endmodule
